### design/bgs_pkg.sv
// ----------------------------------------------------------------------------
// bgs_pkg: shared types and constants for the blower and gate sequencer
// Holds the state encodings, the result mode codes, register indexes and
// reset values of the configuration registers.
// ----------------------------------------------------------------------------
package bgs_pkg;

    // Field and register widths
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned DUR_W      = 3;
    localparam int unsigned MAIN_TMR_W = 11;
    localparam int unsigned GATE_TMR_W = 8;
    localparam int unsigned WIPER_W    = 9;
    localparam int unsigned SHOTS_W    = 2;
    localparam int unsigned CODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;

    // Input actions
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INIT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIRE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PURGE_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_TICKS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRE_SPEED   = 2'd3;

    // Reset values of the configuration registers
    localparam logic [MAIN_TMR_W-1:0] PURGE_TICKS_RST = 11'd500;
    localparam logic [MAIN_TMR_W-1:0] FIRE_PERIOD_RST = 11'd1750;
    localparam logic [GATE_TMR_W-1:0] SWING_TICKS_RST = 8'd75;
    localparam logic [WIPER_W-1:0]    FIRE_SPEED_RST  = 9'd23;

    // Wiper levels
    localparam logic [WIPER_W-1:0] WIPER_FULL = 9'd256;
    localparam logic [WIPER_W-1:0] WIPER_ZERO = 9'd0;

    // Fire duration clamp
    localparam logic [SHOTS_W-1:0] SHOTS_MIN = 2'd1;
    localparam logic [SHOTS_W-1:0] SHOTS_MAX = 2'd3;

    // Gate positions
    localparam logic [CODE_W-1:0] POS_UNSET = 2'd0;
    localparam logic [CODE_W-1:0] POS_BLOCK = 2'd1;
    localparam logic [CODE_W-1:0] POS_ONE   = 2'd2;
    localparam logic [CODE_W-1:0] POS_TWO   = 2'd3;

    // Sensor commands
    localparam logic [CODE_W-1:0] SENSE_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] SENSE_START = 2'd1;
    localparam logic [CODE_W-1:0] SENSE_STOP  = 2'd2;

    // Mode codes reported on the result beat
    localparam logic [CODE_W-1:0] MAIN_CODE_OFF     = 2'd0;
    localparam logic [CODE_W-1:0] MAIN_CODE_PURGING = 2'd1;
    localparam logic [CODE_W-1:0] MAIN_CODE_READY   = 2'd2;
    localparam logic [CODE_W-1:0] MAIN_CODE_FIRING  = 2'd3;
    localparam logic [CODE_W-1:0] GATE_CODE_OFF     = 2'd0;
    localparam logic [CODE_W-1:0] GATE_CODE_BLOCK   = 2'd1;
    localparam logic [CODE_W-1:0] GATE_CODE_MOVE1   = 2'd2;
    localparam logic [CODE_W-1:0] GATE_CODE_MOVE2   = 2'd3;

    // State machines, one-hot
    typedef enum logic [3:0] {
        MAIN_OFF     = 4'b0001,
        MAIN_PURGING = 4'b0010,
        MAIN_READY   = 4'b0100,
        MAIN_FIRING  = 4'b1000
    } main_state_t;

    typedef enum logic [3:0] {
        GATE_OFF   = 4'b0001,
        GATE_BLOCK = 4'b0010,
        GATE_MOVE1 = 4'b0100,
        GATE_MOVE2 = 4'b1000
    } gate_state_t;

    function automatic logic [CODE_W-1:0] main_code(input main_state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            MAIN_PURGING: code = MAIN_CODE_PURGING;
            MAIN_READY:   code = MAIN_CODE_READY;
            MAIN_FIRING:  code = MAIN_CODE_FIRING;
            default:      code = MAIN_CODE_OFF;
        endcase
        return code;
    endfunction

    function automatic logic [CODE_W-1:0] gate_code(input gate_state_t st);
        logic [CODE_W-1:0] code;
        case (st)
            GATE_BLOCK: code = GATE_CODE_BLOCK;
            GATE_MOVE1: code = GATE_CODE_MOVE1;
            GATE_MOVE2: code = GATE_CODE_MOVE2;
            default:    code = GATE_CODE_OFF;
        endcase
        return code;
    endfunction

endpackage

### design/blower_and_gate_sequencer_core.sv
// ----------------------------------------------------------------------------
// blower_and_gate_sequencer_core: blower and gate servo sequencer
// An accepted input beat gives its result beat from the output register in the next cycle.
// Throughput: one beat per cycle; the single state update and the output
// register sustain that rate while the result side takes every beat.
// Reset: both machines off, timers and levels zero, gate unset, config
// registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
module blower_and_gate_sequencer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bgs_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bgs_pkg::ACTION_W-1:0]        action,
    input  logic [bgs_pkg::DUR_W-1:0]           fire_duration,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bgs_pkg::WIPER_W-1:0]         enable_wiper,
    output logic [bgs_pkg::WIPER_W-1:0]         speed_wiper,
    output logic [bgs_pkg::CODE_W-1:0]          gate_position,
    output logic [bgs_pkg::CODE_W-1:0]          sensor_command,
    output logic [bgs_pkg::CODE_W-1:0]          main_mode,
    output logic [bgs_pkg::CODE_W-1:0]          gate_mode,
    output logic                                fire_done
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bgs_pkg::MAIN_TMR_W-1:0] purge_ticks_reg;
    logic [bgs_pkg::MAIN_TMR_W-1:0] fire_period_reg;
    logic [bgs_pkg::GATE_TMR_W-1:0] swing_ticks_reg;
    logic [bgs_pkg::WIPER_W-1:0]    fire_speed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            purge_ticks_reg <= bgs_pkg::PURGE_TICKS_RST;
            fire_period_reg <= bgs_pkg::FIRE_PERIOD_RST;
            swing_ticks_reg <= bgs_pkg::SWING_TICKS_RST;
            fire_speed_reg  <= bgs_pkg::FIRE_SPEED_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgs_pkg::REG_PURGE_TICKS: purge_ticks_reg <= cfg_data;
                bgs_pkg::REG_FIRE_PERIOD: fire_period_reg <= cfg_data;
                bgs_pkg::REG_SWING_TICKS:
                    swing_ticks_reg <= cfg_data[bgs_pkg::GATE_TMR_W-1:0];
                bgs_pkg::REG_FIRE_SPEED:
                    fire_speed_reg <= cfg_data[bgs_pkg::WIPER_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    bgs_pkg::main_state_t main_reg, main_next;
    bgs_pkg::gate_state_t gate_reg, gate_next;
    logic [bgs_pkg::MAIN_TMR_W-1:0] main_timer_reg, main_timer_next;
    logic [bgs_pkg::GATE_TMR_W-1:0] gate_timer_reg, gate_timer_next;
    logic [bgs_pkg::SHOTS_W-1:0]    shots_reg, shots_next;
    logic [bgs_pkg::WIPER_W-1:0]    enable_level_reg, enable_level_next;
    logic [bgs_pkg::WIPER_W-1:0]    speed_level_reg, speed_level_next;
    logic [bgs_pkg::CODE_W-1:0]     gate_level_reg, gate_level_next;
    logic [bgs_pkg::CODE_W-1:0]     sensor_next;
    logic                           done_next;

    // Output register: a beat is accepted whenever the result slot is free
    // or is being emptied in the same cycle.
    logic out_valid_reg, out_valid_next;
    logic in_accept;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    // Incremented timers carry one extra bit so a zero limit still expires.
    logic [bgs_pkg::MAIN_TMR_W:0] main_inc;
    logic [bgs_pkg::GATE_TMR_W:0] gate_inc;
    logic                         main_limit_hit;
    logic                         swing_hit;
    logic [bgs_pkg::SHOTS_W-1:0]  dur_clamped;
    logic [bgs_pkg::SHOTS_W-1:0]  shots_dec;
    logic [bgs_pkg::WIPER_W-1:0]  fire_speed_sat;

    always_comb
    begin
        main_inc = {1'b0, main_timer_reg} + 1'b1;
        gate_inc = {1'b0, gate_timer_reg} + 1'b1;
        // The firing period and the purge length share the main timer.
        if (main_reg == bgs_pkg::MAIN_FIRING)
            main_limit_hit = main_inc >= {1'b0, fire_period_reg};
        else
            main_limit_hit = main_inc >= {1'b0, purge_ticks_reg};
        swing_hit = gate_inc >= {1'b0, swing_ticks_reg};

        // Clamp the requested duration to one..three periods.
        if (fire_duration == '0)
            dur_clamped = bgs_pkg::SHOTS_MIN;
        else if (fire_duration > bgs_pkg::DUR_W'(bgs_pkg::SHOTS_MAX))
            dur_clamped = bgs_pkg::SHOTS_MAX;
        else
            dur_clamped = fire_duration[bgs_pkg::SHOTS_W-1:0];

        // An exhausted counter counts as the last period.
        shots_dec = (shots_reg != '0) ? shots_reg - 1'b1 : shots_reg;

        fire_speed_sat = (fire_speed_reg > bgs_pkg::WIPER_FULL) ? bgs_pkg::WIPER_FULL
                                                                : fire_speed_reg;
    end

    // ------------------------------------------------------------------
    // Next-state logic: one event per accepted beat
    // ------------------------------------------------------------------
    always_comb
    begin
        main_next         = main_reg;
        gate_next         = gate_reg;
        main_timer_next   = main_timer_reg;
        gate_timer_next   = gate_timer_reg;
        shots_next        = shots_reg;
        enable_level_next = enable_level_reg;
        speed_level_next  = speed_level_reg;
        gate_level_next   = gate_level_reg;
        sensor_next       = bgs_pkg::SENSE_NONE;
        done_next         = 1'b0;

        case (action)
            bgs_pkg::ACT_INIT:
            begin
                // Start purging with the blower enabled, speed at fastest, and block the gate.
                if (main_reg == bgs_pkg::MAIN_OFF)
                begin
                    main_next         = bgs_pkg::MAIN_PURGING;
                    main_timer_next   = '0;
                    enable_level_next = bgs_pkg::WIPER_FULL;
                    speed_level_next  = bgs_pkg::WIPER_ZERO;
                end
                if (gate_reg == bgs_pkg::GATE_OFF)
                begin
                    gate_next       = bgs_pkg::GATE_BLOCK;
                    gate_timer_next = '0;
                    gate_level_next = bgs_pkg::POS_BLOCK;
                end
            end

            bgs_pkg::ACT_FIRE:
            begin
                // Load the shot count in every main state.
                shots_next = dur_clamped;
                if (main_reg == bgs_pkg::MAIN_READY)
                begin
                    main_next         = bgs_pkg::MAIN_FIRING;
                    main_timer_next   = '0;
                    enable_level_next = bgs_pkg::WIPER_FULL;
                    speed_level_next  = fire_speed_sat;
                    sensor_next       = bgs_pkg::SENSE_START;
                end
                // The gate starts swinging even if the main side is busy.
                if (gate_reg == bgs_pkg::GATE_BLOCK)
                begin
                    gate_next       = bgs_pkg::GATE_MOVE1;
                    gate_timer_next = '0;
                    gate_level_next = bgs_pkg::POS_ONE;
                end
            end

            bgs_pkg::ACT_TICK:
            begin
                // Alternate the gate every swing period.
                if (gate_reg inside {bgs_pkg::GATE_MOVE1, bgs_pkg::GATE_MOVE2})
                begin
                    if (swing_hit)
                    begin
                        gate_timer_next = '0;
                        if (gate_reg == bgs_pkg::GATE_MOVE1)
                        begin
                            gate_next       = bgs_pkg::GATE_MOVE2;
                            gate_level_next = bgs_pkg::POS_TWO;
                        end
                        else
                        begin
                            gate_next       = bgs_pkg::GATE_MOVE1;
                            gate_level_next = bgs_pkg::POS_ONE;
                        end
                    end
                    else
                    begin
                        gate_timer_next = gate_inc[bgs_pkg::GATE_TMR_W-1:0];
                    end
                end

                if (main_reg == bgs_pkg::MAIN_PURGING)
                begin
                    if (main_limit_hit)
                    begin
                        main_next         = bgs_pkg::MAIN_READY;
                        main_timer_next   = '0;
                        enable_level_next = bgs_pkg::WIPER_ZERO;
                    end
                    else
                    begin
                        main_timer_next = main_inc[bgs_pkg::MAIN_TMR_W-1:0];
                    end
                end
                else if (main_reg == bgs_pkg::MAIN_FIRING)
                begin
                    if (main_limit_hit)
                    begin
                        main_timer_next = '0;
                        shots_next      = shots_dec;
                        if (shots_dec == '0)
                        begin
                            // Last period: stop the blower and park the gate now,
                            // overriding any swing taken above.
                            main_next         = bgs_pkg::MAIN_READY;
                            enable_level_next = bgs_pkg::WIPER_ZERO;
                            sensor_next       = bgs_pkg::SENSE_STOP;
                            done_next         = 1'b1;
                            if (gate_reg inside {bgs_pkg::GATE_MOVE1, bgs_pkg::GATE_MOVE2})
                            begin
                                gate_next       = bgs_pkg::GATE_BLOCK;
                                gate_timer_next = '0;
                                gate_level_next = bgs_pkg::POS_BLOCK;
                            end
                        end
                    end
                    else
                    begin
                        main_timer_next = main_inc[bgs_pkg::MAIN_TMR_W-1:0];
                    end
                end
            end

            default: ; // unused action code: hold everything
        endcase
    end

    // Hold the result beat until taken; load a new one on every accept.
    assign out_valid_next = in_accept | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_reg         <= bgs_pkg::MAIN_OFF;
            gate_reg         <= bgs_pkg::GATE_OFF;
            main_timer_reg   <= '0;
            gate_timer_reg   <= '0;
            shots_reg        <= '0;
            enable_level_reg <= bgs_pkg::WIPER_ZERO;
            speed_level_reg  <= bgs_pkg::WIPER_ZERO;
            gate_level_reg   <= bgs_pkg::POS_UNSET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                main_reg         <= main_next;
                gate_reg         <= gate_next;
                main_timer_reg   <= main_timer_next;
                gate_timer_reg   <= gate_timer_next;
                shots_reg        <= shots_next;
                enable_level_reg <= enable_level_next;
                speed_level_reg  <= speed_level_next;
                gate_level_reg   <= gate_level_next;
            end
        end
    end

    // Result payload registers: no reset needed, qualified by out_valid.
    logic [bgs_pkg::WIPER_W-1:0] enable_wiper_reg, speed_wiper_reg;
    logic [bgs_pkg::CODE_W-1:0]  gate_position_reg, sensor_command_reg;
    logic [bgs_pkg::CODE_W-1:0]  main_mode_reg, gate_mode_reg;
    logic                        fire_done_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            enable_wiper_reg   <= enable_level_next;
            speed_wiper_reg    <= speed_level_next;
            gate_position_reg  <= gate_level_next;
            sensor_command_reg <= sensor_next;
            main_mode_reg      <= bgs_pkg::main_code(main_next);
            gate_mode_reg      <= bgs_pkg::gate_code(gate_next);
            fire_done_reg      <= done_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign enable_wiper   = enable_wiper_reg;
    assign speed_wiper    = speed_wiper_reg;
    assign gate_position  = gate_position_reg;
    assign sensor_command = sensor_command_reg;
    assign main_mode      = main_mode_reg;
    assign gate_mode      = gate_mode_reg;
    assign fire_done      = fire_done_reg;

`ifndef NO_ASSERTIONS
    // Every accepted beat yields a result beat in the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("accepted beat produced no result");

    // The done pulse leaves the main machine ready.
    a_done_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fire_done) |-> (main_mode == bgs_pkg::MAIN_CODE_READY))
        else $error("fire_done without ready main mode");

    // The done pulse parks a swinging gate in the same step.
    a_done_gate_parked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fire_done) |->
            (gate_mode != bgs_pkg::GATE_CODE_MOVE1 && gate_mode != bgs_pkg::GATE_CODE_MOVE2))
        else $error("gate still moving after fire_done");

    // A start command only comes with entry into firing at full enable.
    a_start_firing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && sensor_command == bgs_pkg::SENSE_START) |->
            (main_mode == bgs_pkg::MAIN_CODE_FIRING && enable_wiper == bgs_pkg::WIPER_FULL))
        else $error("sensor start outside firing entry");

    // Machine states stay one-hot.
    a_onehot_states: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(main_reg) && $onehot(gate_reg))
        else $error("state register lost one-hot encoding");
`endif

endmodule
